### hdl/ttt_pkg.sv
// shared types, constants and codes for the tick timer table
// used by ttt_ctrl, ttt_dpath and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

    // table size and derived widths
    localparam int unsigned MAX_TIMERS = 32;
    localparam int unsigned RESULT_CAP = 32;
    localparam int unsigned IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int unsigned CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int unsigned CMP_W      = (CNT_W > 6) ? CNT_W : 6;

    // config register reset value
    localparam logic [5:0] LIMIT_RESET = 6'd32;

    // item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_KILL = 2'd2;

    // timer kinds
    localparam logic [1:0] KIND_ONE_SHOT = 2'd1;
    localparam logic [1:0] KIND_PERIODIC = 2'd2;

    // result event codes
    localparam logic [2:0] EV_SET_OK      = 3'd0;
    localparam logic [2:0] EV_SET_REFUSED = 3'd1;
    localparam logic [2:0] EV_KILLED      = 3'd2;
    localparam logic [2:0] EV_KILL_REFUSED = 3'd3;
    localparam logic [2:0] EV_EXPIRED     = 3'd4;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] interval;
        logic [1:0]  timer_kind;
        logic [5:0]  kill_id;
        logic [15:0] user_tag;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [2:0]  event_res;
        logic [5:0]  res_id;
        logic [15:0] tag;
        logic        last;
    } t_out_word;

    // one slot entry held in the slot ram
    typedef struct packed {
        logic [31:0] interval;
        logic [31:0] elapsed;
        logic        periodic;
        logic [15:0] tag;
    } t_slot;

    localparam int unsigned SLOT_W = $bits(t_slot);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FLUSH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec_op;
        logic slot_adv;
        logic ev_commit;
        logic flush;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic is_op;
        logic out_free;
        logic cur_valid;
        logic cur_last;
        logic ev_block;
        logic pend_valid;
    } t_ctl_sts;

endpackage

`default_nettype wire

### hdl/ttt_ram.sv
// generic single write port ram with registered read
// stand-alone; no package needed
`timescale 1ns / 1ps
`default_nettype none

module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                                               i_clk,
    input  wire                                               i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       i_waddr,
    input  wire [WIDTH-1:0]                                   i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       i_raddr,
    output logic [WIDTH-1:0]                                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/ttt_ctrl.sv
// controller state machine for the tick timer table
// depends on ttt_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module ttt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  ttt_pkg::t_ctl_sts i_sts,
    output ttt_pkg::t_ctl_cmd o_cmd
);

    ttt_pkg::t_state r_state;
    ttt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttt_pkg::S_EXEC;
                end
            end
            ttt_pkg::S_EXEC: begin
                if (i_sts.is_tick) begin
                    n_state = ttt_pkg::S_SCAN_RD;
                end else if (!i_sts.is_op || i_sts.out_free) begin
                    n_state = ttt_pkg::S_IDLE;
                end
            end
            ttt_pkg::S_SCAN_RD: begin
                if (i_sts.cur_valid) begin
                    n_state = ttt_pkg::S_SCAN_EV;
                end else if (i_sts.cur_last) begin
                    n_state = ttt_pkg::S_FLUSH;
                end
            end
            ttt_pkg::S_SCAN_EV: begin
                if (!i_sts.ev_block) begin
                    n_state = i_sts.cur_last ? ttt_pkg::S_FLUSH : ttt_pkg::S_SCAN_RD;
                end
            end
            ttt_pkg::S_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    n_state = ttt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttt_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ttt_pkg::S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ttt_pkg::S_EXEC: begin
                o_cmd.exec_op = i_sts.is_op && i_sts.out_free;
            end
            ttt_pkg::S_SCAN_RD: begin
                o_cmd.slot_adv = !i_sts.cur_valid && !i_sts.cur_last;
            end
            ttt_pkg::S_SCAN_EV: begin
                o_cmd.ev_commit = !i_sts.ev_block;
                o_cmd.slot_adv  = !i_sts.ev_block && !i_sts.cur_last;
            end
            ttt_pkg::S_FLUSH: begin
                o_cmd.flush = i_sts.pend_valid && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/ttt_dpath.sv
// datapath of the tick timer table: item register, valid bits, slot ram,
// pending expiry and output register; depends on ttt_pkg and ttt_ram
`timescale 1ns / 1ps
`default_nettype none

module ttt_dpath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ttt_pkg::t_in_word  i_in_word,
    input  wire                i_out_stall,
    output logic               o_out_valid,
    output ttt_pkg::t_out_word o_out_word,
    input  wire                i_cfg_we,
    input  wire [5:0]          i_cfg_wdata,
    input  ttt_pkg::t_ctl_cmd  i_cmd,
    output ttt_pkg::t_ctl_sts  o_sts
);

    // registers
    ttt_pkg::t_in_word              r_item;
    logic [5:0]                     r_limit;
    logic [ttt_pkg::CNT_W-1:0]      r_issued;
    logic [ttt_pkg::CNT_W-1:0]      n_issued;
    logic [ttt_pkg::MAX_TIMERS-1:0] r_valid;
    logic [ttt_pkg::MAX_TIMERS-1:0] n_valid;
    logic [ttt_pkg::IDX_W-1:0]      r_slot;
    logic [ttt_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_pend_valid;
    logic                           n_pend_valid;
    ttt_pkg::t_out_word             r_pend;
    ttt_pkg::t_out_word             n_pend;
    logic                           r_out_valid;
    logic                           n_out_valid;
    ttt_pkg::t_out_word             r_out_word;
    ttt_pkg::t_out_word             n_out_word;

    // combinational
    ttt_pkg::t_slot                 w_rd;
    ttt_pkg::t_slot                 w_wdata;
    logic                           w_we;
    logic [ttt_pkg::IDX_W-1:0]      w_waddr;
    logic                           w_out_free;
    logic [ttt_pkg::CMP_W-1:0]      w_issued_ext;
    logic [ttt_pkg::CMP_W-1:0]      w_new_id;
    logic [ttt_pkg::CMP_W-1:0]      w_kid;
    logic [ttt_pkg::IDX_W-1:0]      w_kidx;
    logic [ttt_pkg::CMP_W-1:0]      w_slot_id;
    logic                           w_is_set;
    logic                           w_is_kill;
    logic                           w_set_ok;
    logic                           w_kill_ok;
    logic [31:0]                    w_inc;
    logic                           w_hit;
    logic                           w_report;

    // slot ram: interval, elapsed, periodic flag and tag
    ttt_ram #(
        .WIDTH (ttt_pkg::SLOT_W),
        .DEPTH (ttt_pkg::MAX_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rd)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // set and kill decode
    assign w_is_set     = (r_item.mode == ttt_pkg::MODE_SET);
    assign w_is_kill    = (r_item.mode == ttt_pkg::MODE_KILL);
    assign w_issued_ext = (ttt_pkg::CMP_W)'(r_issued);
    assign w_new_id     = w_issued_ext + 1'b1;
    assign w_set_ok     = (r_item.interval != 32'd0)
                       && ((r_item.timer_kind == ttt_pkg::KIND_ONE_SHOT)
                        || (r_item.timer_kind == ttt_pkg::KIND_PERIODIC))
                       && (w_issued_ext < (ttt_pkg::CMP_W)'(r_limit))
                       && (w_issued_ext < (ttt_pkg::CMP_W)'(ttt_pkg::MAX_TIMERS));
    assign w_kid        = (ttt_pkg::CMP_W)'(r_item.kill_id);
    assign w_kidx       = (ttt_pkg::IDX_W)'(w_kid - 1'b1);
    assign w_kill_ok    = (w_kid != '0)
                       && (w_kid <= (ttt_pkg::CMP_W)'(ttt_pkg::MAX_TIMERS))
                       && r_valid[w_kidx];

    // tick evaluation of the slot just read
    assign w_inc     = w_rd.elapsed + 32'd1;
    assign w_hit     = (w_inc == w_rd.interval);
    assign w_report  = w_hit && (32'(r_cnt) < ttt_pkg::RESULT_CAP);
    assign w_slot_id = (ttt_pkg::CMP_W)'(r_slot) + 1'b1;

    // status to controller
    always_comb begin
        o_sts.is_tick    = (r_item.mode == ttt_pkg::MODE_TICK);
        o_sts.is_op      = w_is_set || w_is_kill;
        o_sts.out_free   = w_out_free;
        o_sts.cur_valid  = r_valid[r_slot];
        o_sts.cur_last   = (r_slot == (ttt_pkg::IDX_W)'(ttt_pkg::MAX_TIMERS - 1));
        o_sts.ev_block   = w_report && r_pend_valid && !w_out_free;
        o_sts.pend_valid = r_pend_valid;
    end

    // ram write: arm on set, write back elapsed on tick
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = w_rd;
        if (i_cmd.exec_op && w_is_set && w_set_ok) begin
            w_we             = 1'b1;
            w_waddr          = (ttt_pkg::IDX_W)'(r_issued);
            w_wdata.interval = r_item.interval;
            w_wdata.elapsed  = 32'd0;
            w_wdata.periodic = (r_item.timer_kind == ttt_pkg::KIND_PERIODIC);
            w_wdata.tag      = r_item.user_tag;
        end else if (i_cmd.ev_commit) begin
            w_we            = 1'b1;
            w_wdata.elapsed = w_hit ? 32'd0 : w_inc;
        end
    end

    // issue count and valid bits
    always_comb begin
        n_issued = r_issued;
        n_valid  = r_valid;
        if (i_cmd.exec_op && w_is_set && w_set_ok) begin
            n_issued = r_issued + 1'b1;
            n_valid[(ttt_pkg::IDX_W)'(r_issued)] = 1'b1;
        end
        if (i_cmd.exec_op && w_is_kill && w_kill_ok) begin
            n_valid[w_kidx] = 1'b0;
        end
        if (i_cmd.ev_commit && w_hit && !w_rd.periodic) begin
            n_valid[r_slot] = 1'b0;
        end
    end

    // pending expiry and output word
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        if (i_cmd.load_item) begin
            n_pend_valid = 1'b0;
        end
        if (i_cmd.exec_op) begin
            n_out_valid = 1'b1;
            n_out_word.tag  = 16'd0;
            n_out_word.last = 1'b1;
            if (w_is_set) begin
                n_out_word.event_res = w_set_ok ? ttt_pkg::EV_SET_OK
                                                : ttt_pkg::EV_SET_REFUSED;
                n_out_word.res_id    = w_set_ok ? w_new_id[5:0] : 6'd0;
            end else begin
                n_out_word.event_res = w_kill_ok ? ttt_pkg::EV_KILLED
                                                 : ttt_pkg::EV_KILL_REFUSED;
                n_out_word.res_id    = r_item.kill_id;
            end
        end
        if (i_cmd.ev_commit && w_report) begin
            // older expiry goes out, newest is held until we know it is last
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_word  = r_pend;
            end
            n_pend_valid     = 1'b1;
            n_pend.event_res = ttt_pkg::EV_EXPIRED;
            n_pend.res_id    = w_slot_id[5:0];
            n_pend.tag       = w_rd.tag;
            n_pend.last      = 1'b0;
        end
        if (i_cmd.flush) begin
            n_out_valid     = 1'b1;
            n_out_word      = r_pend;
            n_out_word.last = 1'b1;
            n_pend_valid    = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= ttt_pkg::LIMIT_RESET;
            r_issued     <= '0;
            r_valid      <= '0;
            r_slot       <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_issued     <= n_issued;
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cmd.load_item) begin
                r_slot <= '0;
                r_cnt  <= '0;
            end else begin
                if (i_cmd.slot_adv) begin
                    r_slot <= r_slot + 1'b1;
                end
                if (i_cmd.ev_commit && w_report) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        r_pend     <= n_pend;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### hdl/tick_timer_table.sv
// top level of the tick timer table: controller plus datapath
// depends on ttt_pkg, ttt_ctrl, ttt_dpath and ttt_ram
//
// A table of MAX_TIMERS timer slots. A set word arms the slot of the next
// identifier (1, 2, 3, ... never reused, limited by the timer_limit register),
// a kill word frees a slot by identifier, and a tick word steps every armed
// slot in identifier order, reporting one expired result per slot that hits
// its interval; one-shot slots are freed, periodic slots restart. Each input
// word is taken into an item register, so a new word is accepted while the
// previous result still waits at the output. A tick walks the slot ram one
// slot at a time: an idle slot is passed over, and an armed slot takes a
// registered ram read, then update and write back; the walk is longer while
// the output is stalled. Each expiry of a tick is held back until the next
// expiry or the end of the walk so the final one can carry the last flag.
// Mode 3 and ticks with no expiry give no result. Write timer_limit only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module tick_timer_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  ttt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ttt_pkg::t_out_word o_out_word,
    input  wire                i_cfg_we,
    input  wire [5:0]          i_cfg_wdata
);

    ttt_pkg::t_ctl_cmd w_cmd;
    ttt_pkg::t_ctl_sts w_sts;

    // sequencing
    ttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot storage and result path
    ttt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

`default_nettype wire
